// ===== rtl/nds_pkg.sv =====
package nds_pkg;

    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned IN_DATA_W = 32;
    localparam int unsigned OUT_DATA_W = 32;
    localparam int unsigned IDX_W = 4;
    localparam int unsigned EXT_W = 4;
    localparam int unsigned DIMS_W = 3;
    localparam int unsigned NUM_EXT = 4;
    localparam int unsigned ACC_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 4;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_COUNT = 2'd1,
        ST_RANGE = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_3 = 3'd4;

    typedef struct packed {
        logic start;
        logic calc;
        logic decide;
        logic fill_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_step;
        logic is_fill;
        logic fill_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/nds_ctrl.sv =====
module nds_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  nds_pkg::dp_stat_t  stat,
    output nds_pkg::ctrl_cmd_t cmd
);
    import nds_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DECIDE,
        S_FILL,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;

    always_comb begin
        cmd.start     = s_axis_tvalid && s_tready_reg;
        cmd.calc      = (state_reg == S_CALC);
        cmd.decide    = (state_reg == S_DECIDE);
        cmd.fill_step = (state_reg == S_FILL) && !stat.fill_done;
        cmd.out_load  = (state_reg == S_FINISH) && stat.out_free;
    end

    always_comb begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.start) begin
                    state_next    = S_CALC;
                    s_tready_next = 1'b0;
                end
            end
            S_CALC: begin
                if (stat.last_step) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = stat.is_fill ? S_FILL : S_FINISH;
            end
            S_FILL: begin
                if (stat.fill_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    state_next    = S_IDLE;
                    s_tready_next = 1'b1;
                end
            end
            default: begin
                state_next    = S_IDLE;
                s_tready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

    assign s_axis_tready = s_tready_reg;

endmodule

// ===== rtl/nds_dpath.sv =====
module nds_dpath #(
    parameter int unsigned MAX_DIMS    = 4,
    parameter int unsigned MAX_EXTENT  = 8,
    parameter int unsigned DATA_WIDTH  = 32,
    parameter int unsigned STORE_DEPTH = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [nds_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [nds_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [nds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nds_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  nds_pkg::ctrl_cmd_t                  cmd,
    output nds_pkg::dp_stat_t                   stat
);
    import nds_pkg::*;

    localparam int unsigned DIM_LIMIT = (MAX_DIMS < NUM_EXT) ? MAX_DIMS : NUM_EXT;
    localparam int unsigned ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);

    // config registers
    logic [DIMS_W-1:0] num_dims_reg;
    logic [EXT_W-1:0]  extent_reg [NUM_EXT];

    // request word
    logic [1:0]            op_reg;
    logic [DIMS_W-1:0]     nidx_reg;
    logic [IDX_W-1:0]      idx_reg [NUM_EXT];
    logic [IN_DATA_W-1:0]  data_reg;

    // address / size accumulation
    logic [ACC_W-1:0] acc_reg;
    logic             bad_reg;
    logic [1:0]       step_reg;

    logic [1:0]            res_status_reg;
    logic                  sel_mem_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [CNT_W-1:0]      fill_cnt_reg;
    logic [CNT_W-1:0]      fill_end_reg;

    logic                  m_tvalid_reg;
    logic [1:0]            out_status_reg;
    logic [OUT_DATA_W-1:0] out_value_reg;

    logic [DATA_WIDTH-1:0] mem [STORE_DEPTH];

    logic [DIMS_W-1:0] used_dims;
    logic [EXT_W-1:0]  ext_used [NUM_EXT];
    logic [EXT_W-1:0]  cur_ext;
    logic [IDX_W-1:0]  cur_idx;
    logic              idx_bad;
    logic [ACC_W-1:0]  acc_step;
    logic              is_fill, is_rw, count_err, range_err, access_ok;
    logic [1:0]        res_status;
    logic              wr_single, rd_en, mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [CNT_W-1:0]  fill_end;
    logic [1:0]        in_op;

    always_comb begin
        used_dims = num_dims_reg;
        if (num_dims_reg == '0) begin
            used_dims = 3'd1;
        end
        if (32'(used_dims) > DIM_LIMIT) begin
            used_dims = DIMS_W'(DIM_LIMIT);
        end
        for (int i = 0; i < NUM_EXT; i++) begin
            ext_used[i] = (32'(extent_reg[i]) > MAX_EXTENT) ? EXT_W'(MAX_EXTENT) : extent_reg[i];
        end
    end

    assign cur_ext  = ext_used[step_reg];
    assign cur_idx  = idx_reg[step_reg];
    assign is_fill  = (op_reg == CMD_FILL);
    assign is_rw    = (op_reg == CMD_READ) || (op_reg == CMD_WRITE);
    assign idx_bad  = cur_idx[IDX_W-1] || (cur_idx >= cur_ext);
    // row-major: acc = acc * extent + index; a fill runs the product alone
    assign acc_step = ACC_W'(acc_reg * ACC_W'(cur_ext))
                    + (is_fill ? '0 : ACC_W'(cur_idx));

    assign count_err = (nidx_reg != used_dims);
    assign range_err = bad_reg || (32'(acc_reg) >= STORE_DEPTH);
    assign access_ok = is_rw && !count_err && !range_err;

    always_comb begin
        res_status = ST_OK;
        if (is_rw) begin
            if (count_err) begin
                res_status = ST_COUNT;
            end else if (range_err) begin
                res_status = ST_RANGE;
            end
        end
    end

    assign wr_single = cmd.decide && access_ok && (op_reg == CMD_WRITE);
    assign rd_en     = cmd.decide && access_ok && (op_reg == CMD_READ);
    assign mem_we    = wr_single || cmd.fill_step;
    assign mem_addr  = cmd.fill_step ? fill_cnt_reg[ADDR_W-1:0] : ADDR_W'(acc_reg);
    assign fill_end  = (32'(acc_reg) > STORE_DEPTH) ? CNT_W'(STORE_DEPTH) : CNT_W'(acc_reg);
    assign in_op     = s_axis_tdata[1:0];

    assign stat.last_step = (DIMS_W'(step_reg) == (used_dims - 3'd1));
    assign stat.is_fill   = is_fill;
    assign stat.fill_done = (fill_cnt_reg >= fill_end_reg);
    assign stat.out_free  = !m_tvalid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg  <= 3'd3;
            extent_reg[0] <= 4'd3;
            extent_reg[1] <= 4'd3;
            extent_reg[2] <= 4'd3;
            extent_reg[3] <= 4'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NUM_DIMS: num_dims_reg  <= cfg_wdata[DIMS_W-1:0];
                CFG_EXTENT_0: extent_reg[0] <= cfg_wdata;
                CFG_EXTENT_1: extent_reg[1] <= cfg_wdata;
                CFG_EXTENT_2: extent_reg[2] <= cfg_wdata;
                CFG_EXTENT_3: extent_reg[3] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg     <= in_op;
            nidx_reg   <= s_axis_tdata[4:2];
            idx_reg[0] <= s_axis_tdata[8:5];
            idx_reg[1] <= s_axis_tdata[12:9];
            idx_reg[2] <= s_axis_tdata[16:13];
            idx_reg[3] <= s_axis_tdata[20:17];
            data_reg   <= s_axis_tdata[52:21];
            acc_reg    <= (in_op == CMD_FILL) ? ACC_W'(1) : '0;
            bad_reg    <= 1'b0;
            step_reg   <= '0;
        end else if (cmd.calc) begin
            acc_reg  <= acc_step;
            bad_reg  <= bad_reg || idx_bad;
            step_reg <= step_reg + 2'd1;
        end
        if (cmd.decide) begin
            res_status_reg <= res_status;
            sel_mem_reg    <= rd_en;
            fill_cnt_reg   <= '0;
            fill_end_reg   <= fill_end;
        end else if (cmd.fill_step) begin
            fill_cnt_reg <= fill_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= DATA_WIDTH'(data_reg);
        end
        if (rd_en) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= sel_mem_reg ? OUT_DATA_W'(rd_data_reg) : '0;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {6'd0, out_status_reg, out_value_reg};

endmodule

// ===== rtl/nd_array_indexed_store.sv =====
// Each word: index walk in S_CALC, check in S_DECIDE, fill in S_FILL (fill only), result
// load in S_FINISH. Entries a fill writes: product of extents, capped at STORE_DEPTH.
// One word at a time: the next is taken after the result loads. The index walk takes
// one dimension a cycle through one multiply-add; a fill writes one memory entry a cycle.
// Reset (aresetn, synchronous) restores the configuration registers and empties the
// output register; store contents are left as they are, no clearing pass.
module nd_array_indexed_store #(
    parameter int unsigned MAX_DIMS    = 4,
    parameter int unsigned MAX_EXTENT  = 8,
    parameter int unsigned DATA_WIDTH  = 32,
    parameter int unsigned STORE_DEPTH = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // cmd, num_indices, index_0, index_1, index_2, index_3, data_value
    input  logic [nds_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_value, status
    output logic [nds_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                           cfg_wr_en,
    input  logic [nds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import nds_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    nds_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    nds_dpath #(
        .MAX_DIMS    (MAX_DIMS),
        .MAX_EXTENT  (MAX_EXTENT),
        .DATA_WIDTH  (DATA_WIDTH),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// ===== rtl/nds_checker.sv =====
module nds_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [nds_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import nds_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[33:32] != ST_RSVD)
        else $error("reserved status code");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[33:32] != ST_OK |-> m_axis_tdata[31:0] == '0)
        else $error("nonzero read value on error");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while one in flight");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind nd_array_indexed_store nds_checker u_nds_checker (.*);

// ===== test/nd_store_checker.sv =====
module nd_store_checker #(
    parameter int unsigned MAX_DIMS    = 4,
    parameter int unsigned MAX_EXTENT  = 8,
    parameter int unsigned DATA_WIDTH  = 32,
    parameter int unsigned STORE_DEPTH = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [nds_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [nds_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                           cfg_wr_en,
    input  logic [nds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nds_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int unsigned                    pending_words,
    output int unsigned                    error_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import nds_pkg::*;

    localparam int unsigned NIDX_LSB = 2;
    localparam int unsigned IDX_LSB  = NIDX_LSB + DIMS_W;
    localparam int unsigned DATA_LSB = IDX_LSB + NUM_EXT * IDX_W;
    localparam int unsigned DIM_CAP  = (MAX_DIMS < NUM_EXT) ? MAX_DIMS : NUM_EXT;

    typedef struct packed {
        logic [OUT_DATA_W-1:0] value;
        status_t               status;
    } reply_t;

    reply_t                expected_replies [$];
    logic [DATA_WIDTH-1:0] element_mem [STORE_DEPTH];
    logic [DIMS_W-1:0]     dims_cfg;
    logic [EXT_W-1:0]      extent_cfg [NUM_EXT];
    int unsigned           fails = 0;

    initial begin
        for (int k = 0; k < STORE_DEPTH; k++) element_mem[k] = '0;
    end

    function automatic int unsigned dims_in_use();
        int unsigned d;
        d = 32'(dims_cfg);
        if (d == 0) d = 1;
        if (d > DIM_CAP) d = DIM_CAP;
        return d;
    endfunction

    function automatic int unsigned extent_in_use(input int unsigned i);
        int unsigned e;
        e = 32'(extent_cfg[i]);
        if (e > MAX_EXTENT) e = MAX_EXTENT;
        return e;
    endfunction

    // updates the element store and returns the reply for one request word
    function automatic reply_t serve_request(input logic [S_TDATA_W-1:0] word);
        cmd_t                  op;
        logic [DIMS_W-1:0]     count;
        logic [IDX_W-1:0]      ix;
        logic [DATA_WIDTH-1:0] value;
        int unsigned           dims, ext, addr, total;
        logic                  bad;
        reply_t                r;
        op    = cmd_t'(word[1:0]);
        count = word[NIDX_LSB +: DIMS_W];
        value = word[DATA_LSB +: DATA_WIDTH];
        dims  = dims_in_use();
        r.value  = '0;
        r.status = ST_OK;
        case (op)
            CMD_FILL: begin
                total = 1;
                for (int i = 0; i < dims; i++) total *= extent_in_use(i);
                if (total > STORE_DEPTH) total = STORE_DEPTH;
                for (int k = 0; k < total; k++) element_mem[k] = value;
            end
            CMD_READ, CMD_WRITE: begin
                if (32'(count) != dims) begin
                    r.status = ST_COUNT;
                end else begin
                    addr = 0;
                    bad  = 1'b0;
                    for (int i = 0; i < dims; i++) begin
                        ix  = word[IDX_LSB + IDX_W * i +: IDX_W];
                        ext = extent_in_use(i);
                        if (ix[IDX_W-1] || 32'(ix) >= ext) bad = 1'b1;
                        addr = addr * ext + 32'(ix);
                    end
                    if (bad || addr >= STORE_DEPTH) begin
                        r.status = ST_RANGE;
                    end else if (op == CMD_READ) begin
                        r.value = element_mem[addr];
                    end else begin
                        element_mem[addr] = value;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        reply_t got;
        reply_t fresh;
        if (!aresetn) begin
            expected_replies.delete();
            dims_cfg      = 3'd3;
            extent_cfg[0] = 4'd3;
            extent_cfg[1] = 4'd3;
            extent_cfg[2] = 4'd3;
            extent_cfg[3] = 4'd1;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_NUM_DIMS: dims_cfg      = cfg_wdata[DIMS_W-1:0];
                    CFG_EXTENT_0: extent_cfg[0] = cfg_wdata;
                    CFG_EXTENT_1: extent_cfg[1] = cfg_wdata;
                    CFG_EXTENT_2: extent_cfg[2] = cfg_wdata;
                    CFG_EXTENT_3: extent_cfg[3] = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.value  = m_axis_tdata[OUT_DATA_W-1:0];
                got.status = status_t'(m_axis_tdata[OUT_DATA_W +: 2]);
                if (expected_replies.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected word, read_value %h status %0d",
                             $time, got.value, got.status);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.value !== want.value) begin
                        fails++;
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.value, got.value);
                    end
                    if (got.status !== want.status) begin
                        fails++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                fresh = serve_request(s_axis_tdata);
                expected_replies.insert(expected_replies.size(), fresh);
            end
        end
        pending_words <= expected_replies.size();
        error_count   <= fails;
    end

endmodule

// ===== test/nd_array_indexed_store_tb.sv =====
module nd_array_indexed_store_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nds_pkg::*;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    int unsigned           pending_words;
    int unsigned           error_count;

    int unsigned           send_idle_pct = 37;
    int unsigned           recv_idle_pct = 68;
    logic                  hold_go       = 1'b0;
    logic                  hold_done     = 1'b0;
    int unsigned           hold_left     = 0;

    // last values written, used to aim the random indices
    logic [DIMS_W-1:0]     dims_set;
    logic [EXT_W-1:0]      extent_set [NUM_EXT];

    nd_array_indexed_store i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    nd_store_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .pending_words (pending_words),
        .error_count   (error_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 400;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic int unsigned dims_now();
        int unsigned d;
        d = 32'(dims_set);
        if (d == 0) d = 1;
        if (d > NUM_EXT) d = NUM_EXT;
        return d;
    endfunction

    function automatic int unsigned extent_now(input int unsigned i);
        int unsigned e;
        e = 32'(extent_set[i]);
        if (e > 8) e = 8;
        return e;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_request(
        input cmd_t op, input logic [DIMS_W-1:0] count,
        input logic [IDX_W-1:0] i0, input logic [IDX_W-1:0] i1,
        input logic [IDX_W-1:0] i2, input logic [IDX_W-1:0] i3,
        input logic [IN_DATA_W-1:0] value);
        logic [S_TDATA_W-1:0] w;
        w = '0;
        w[2 + DIMS_W + 4 * IDX_W + IN_DATA_W - 1:0] = {value, i3, i2, i1, i0, count, op};
        return w;
    endfunction

    task automatic send_request(input logic [S_TDATA_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_shape(input logic [DIMS_W-1:0] nd, input logic [EXT_W-1:0] e0,
                             input logic [EXT_W-1:0] e1, input logic [EXT_W-1:0] e2,
                             input logic [EXT_W-1:0] e3);
        put_reg(CFG_NUM_DIMS, CFG_DATA_W'(nd));
        put_reg(CFG_EXTENT_0, e0);
        put_reg(CFG_EXTENT_1, e1);
        put_reg(CFG_EXTENT_2, e2);
        put_reg(CFG_EXTENT_3, e3);
        cfg_wr_en     <= 1'b0;
        dims_set      = nd;
        extent_set[0] = e0;
        extent_set[1] = e1;
        extent_set[2] = e2;
        extent_set[3] = e3;
    endtask

    task automatic send_random_request();
        cmd_t                 op;
        logic [DIMS_W-1:0]    count;
        logic [IDX_W-1:0]     ix [NUM_EXT];
        logic [IN_DATA_W-1:0] value;
        int unsigned          roll, dims, total;
        dims  = dims_now();
        total = 1;
        for (int i = 0; i < dims; i++) total *= extent_now(i);
        roll  = $urandom_range(99);
        value = $urandom();
        if ($urandom_range(15) == 0) value = $urandom_range(1) ? '1 : '0;
        for (int i = 0; i < NUM_EXT; i++) ix[i] = IDX_W'($urandom_range(15));
        count = DIMS_W'(dims);
        op    = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        if (roll < 3 && total <= 64) begin
            op = CMD_FILL;
        end else if (roll < 8) begin
            op    = CMD_NOP;
            count = DIMS_W'($urandom_range(7));
        end else if (roll < 18) begin
            count = DIMS_W'($urandom_range(7));
        end else if (roll >= 30) begin
            for (int i = 0; i < dims; i++)
                if (extent_now(i) != 0) ix[i] = IDX_W'($urandom_range(extent_now(i) - 1));
        end
        send_request(pack_request(op, count, ix[0], ix[1], ix[2], ix[3], value));
    endtask

    // new shape, then a fill so every in-range read hits a written entry
    task automatic run_phase(input logic [DIMS_W-1:0] nd, input logic [EXT_W-1:0] e0,
                             input logic [EXT_W-1:0] e1, input logic [EXT_W-1:0] e2,
                             input logic [EXT_W-1:0] e3, input int unsigned n_items,
                             input bit with_hold);
        wait_idle();
        set_shape(nd, e0, e1, e2, e3);
        send_request(pack_request(CMD_FILL, 3'd0, 4'h0, 4'h0, 4'h0, 4'h0, $urandom()));
        if (with_hold) hold_go <= 1'b1;
        repeat (n_items) send_random_request();
    endtask

    initial begin
        dims_set      = 3'd3;
        extent_set[0] = 4'd3;
        extent_set[1] = 4'd3;
        extent_set[2] = 4'd3;
        extent_set[3] = 4'd1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset shape 3x3x3
        send_request(pack_request(CMD_FILL,  3'd3, 4'h0, 4'h0, 4'h0, 4'h0, 32'hFFFF_FFFF));
        send_request(pack_request(CMD_READ,  3'd3, 4'h0, 4'h0, 4'h0, 4'h7, 32'h0000_0000));
        send_request(pack_request(CMD_WRITE, 3'd3, 4'h2, 4'h2, 4'h2, 4'h8, 32'h0000_0000));
        send_request(pack_request(CMD_READ,  3'd3, 4'h2, 4'h2, 4'h2, 4'h0, 32'hFFFF_FFFF));
        send_request(pack_request(CMD_WRITE, 3'd3, 4'h1, 4'h2, 4'h0, 4'h0, 32'hA5A5_5A5A));
        send_request(pack_request(CMD_READ,  3'd3, 4'h1, 4'h2, 4'h0, 4'h0, 32'h0000_0000));
        // count mismatch wins over bad indices
        send_request(pack_request(CMD_READ,  3'd4, 4'h8, 4'h7, 4'hF, 4'h3, 32'h0000_0000));
        send_request(pack_request(CMD_READ,  3'd0, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0000_0000));
        send_request(pack_request(CMD_WRITE, 3'd7, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0000_0001));
        // negative and too-large indices
        send_request(pack_request(CMD_READ,  3'd3, 4'h8, 4'h0, 4'h0, 4'h0, 32'h0000_0000));
        send_request(pack_request(CMD_READ,  3'd3, 4'hF, 4'h0, 4'h0, 4'h0, 32'h0000_0000));
        send_request(pack_request(CMD_READ,  3'd3, 4'h0, 4'h7, 4'h0, 4'h0, 32'h0000_0000));
        send_request(pack_request(CMD_WRITE, 3'd3, 4'h0, 4'h0, 4'hF, 4'h0, 32'h1234_5678));
        send_request(pack_request(CMD_WRITE, 3'd3, 4'h0, 4'h0, 4'h3, 4'h0, 32'h1234_5678));
        // the rejected write must not have landed on the aliased entry
        send_request(pack_request(CMD_READ,  3'd3, 4'h0, 4'h1, 4'h0, 4'h0, 32'h0000_0000));
        send_request(pack_request(CMD_NOP,   3'd7, 4'hF, 4'hF, 4'hF, 4'hF, 32'hFFFF_FFFF));
        send_request(pack_request(CMD_NOP,   3'd0, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0000_0000));
        send_request(pack_request(CMD_WRITE, 3'd3, 4'h2, 4'h2, 4'h2, 4'h0, 32'hFFFF_FFFF));
        send_request(pack_request(CMD_READ,  3'd3, 4'h2, 4'h2, 4'h2, 4'h0, 32'h0000_0000));

        run_phase(3'd0, 4'd15, 4'd3, 4'd3, 4'd3, 150, 1'b0);
        run_phase(3'd2, 4'd0,  4'd5, 4'd2, 4'd2, 100, 1'b0);
        run_phase(3'd4, 4'd2,  4'd3, 4'd4, 4'd9, 150, 1'b0);

        send_idle_pct = 68;
        recv_idle_pct <= 37;
        run_phase(3'd7, 4'd8,  4'd8, 4'd8, 4'd8, 120, 1'b0);
        run_phase(3'd4, 4'd1,  4'd1, 4'd1, 4'd1, 150, 1'b0);
        run_phase(3'd1, 4'd1,  4'd7, 4'd7, 4'd7, 80,  1'b0);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_phase(3'd3, 4'd4,  4'd2, 4'd6, 4'd0, 180, 1'b1);
        run_phase(3'd5, 4'd3,  4'd2, 4'd2, 4'd3, 180, 1'b0);
        run_phase(3'd2, 4'd8,  4'd8, 4'd1, 4'd1, 140, 1'b0);

        wait_idle();
        if (error_count == 0 && pending_words == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
